/* rtl/rbp_pkg.sv */
// Shared widths, codes and types for the rice bit packer.
package rbp_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned CntW    = 4;
  localparam int unsigned TotalW  = 17;
  localparam int unsigned FieldW  = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned AccW    = 32;

  localparam logic [WordW-1:0] BUFFER_WORDS_RST = 16'hffff;

  typedef enum logic [ReqW-1:0] {
    REQ_FIXED = 2'd0,
    REQ_RICE  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [CodeW-1:0] {
    RICE_NONE  = 2'd0,
    RICE_ONE   = 2'd1,
    RICE_THREE = 2'd2
  } rice_code_e;

  typedef struct packed {
    logic               word_valid;
    logic [WordW-1:0]   packed_word;
    logic [TotalW-1:0]  words_total;
    logic [StatusW-1:0] status;
    logic               block_done;
  } res_t;

endpackage

/* rtl/rbp_req_if.sv */
// Request channel of the rice bit packer.
interface rbp_req_if;
  logic                            valid;
  logic                            ready;
  logic [rbp_pkg::ReqW-1:0]        req_type;
  logic signed [rbp_pkg::WordW-1:0] sample;
  logic [rbp_pkg::FieldW-1:0]      field_bits;
  logic [rbp_pkg::CodeW-1:0]       rice_code;
  logic                            block_last;

  modport source (
    output valid, req_type, sample, field_bits, rice_code, block_last,
    input  ready
  );

  modport sink (
    input  valid, req_type, sample, field_bits, rice_code, block_last,
    output ready
  );
endinterface

/* rtl/rbp_res_if.sv */
// Result channel of the rice bit packer.
interface rbp_res_if;
  logic                         valid;
  logic                         ready;
  logic                         word_valid;
  logic [rbp_pkg::WordW-1:0]    packed_word;
  logic [rbp_pkg::TotalW-1:0]   words_total;
  logic [rbp_pkg::StatusW-1:0]  status;
  logic                         block_done;

  modport source (
    output valid, word_valid, packed_word, words_total, status, block_done,
    input  ready
  );

  modport sink (
    input  valid, word_valid, packed_word, words_total, status, block_done,
    output ready
  );
endinterface

/* rtl/rice_bit_packer.sv */
// Rice bit packer top level: packs samples MSB-first into 16-bit words.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------------------
//   req_i    | in  | valid / ready    | req_type, sample, field_bits, rice_code,
//            |     |                  | block_last
//   res_o    | out | valid / ready    | word_valid, packed_word, words_total,
//            |     |                  | status, block_done
//   cfg      | in  | cfg_we_i         | cfg_wdata_i (buffer_words)
//
// One request per cycle unless a result stalls; its result follows in the next cycle.
// The packing state updates in the accepting cycle, so requests follow back to back.
// A result held by a stalled sink blocks acceptance only while it is not taken.
// Reset clears the pending bits, the word count and the output valid, and
// sets the capacity to 65535 words.
module rice_bit_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbp_pkg::WordW-1:0]  cfg_wdata_i,
  rbp_req_if.sink                    req_i,
  rbp_res_if.source                  res_o
);

  logic [rbp_pkg::WordW-1:0]  buffer_words_q;
  logic [rbp_pkg::WordW-1:0]  pend_bits_q, pend_bits_d;
  logic [rbp_pkg::CntW-1:0]   pend_cnt_q, pend_cnt_d;
  logic [rbp_pkg::TotalW-1:0] words_done_q, words_done_d;
  logic                       res_valid_q;
  rbp_pkg::res_t              res_q, res_d;
  logic                       acc;
  logic                       full;

  logic [rbp_pkg::FieldW-1:0] fix_len;
  logic [rbp_pkg::TotalW-1:0] fix_mask;
  logic [rbp_pkg::WordW-1:0]  fix_code;

  logic [6:0]                 dbl;
  logic [5:0]                 u_val;
  logic [5:0]                 zeros;
  logic [rbp_pkg::FieldW-1:0] rice_len;
  logic [rbp_pkg::WordW-1:0]  rice_cw;
  logic                       in_range;

  logic [rbp_pkg::FieldW-1:0] app_len;
  logic [rbp_pkg::WordW-1:0]  app_code;
  logic [rbp_pkg::AccW-1:0]   app_acc;
  logic [rbp_pkg::FieldW-1:0] app_total;
  logic [rbp_pkg::CntW-1:0]   app_rest;
  logic [rbp_pkg::AccW-1:0]   app_word;
  logic [rbp_pkg::AccW-1:0]   rest_mask;
  logic [rbp_pkg::FieldW-1:0] flush_sh;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign full        = words_done_q >= {1'b0, buffer_words_q};

  always_comb begin
    fix_len  = (req_i.field_bits > 5'd16) ? 5'd16 : req_i.field_bits;
    fix_mask = (17'd1 << fix_len) - 17'd1;
    fix_code = req_i.sample & fix_mask[rbp_pkg::WordW-1:0];
  end

  always_comb begin
    dbl   = {req_i.sample[5:0], 1'b0};
    u_val = req_i.sample[15] ? ~dbl[5:0] : dbl[5:0];
    case (rbp_pkg::rice_code_e'(req_i.rice_code))
      rbp_pkg::RICE_NONE: begin
        in_range = ($signed(req_i.sample) >= -16'sd6) && ($signed(req_i.sample) <= 16'sd7);
        zeros    = u_val;
        rice_len = 5'(zeros) + 5'd1;
        rice_cw  = 16'd1;
      end
      rbp_pkg::RICE_ONE: begin
        in_range = ($signed(req_i.sample) >= -16'sd11) &&
                   ($signed(req_i.sample) <= 16'sd10);
        zeros    = u_val >> 1;
        rice_len = 5'(zeros) + 5'd2;
        rice_cw  = {14'd0, 1'b1, u_val[0]};
      end
      rbp_pkg::RICE_THREE: begin
        in_range = ($signed(req_i.sample) >= -16'sd28) &&
                   ($signed(req_i.sample) <= 16'sd27);
        zeros    = u_val >> 3;
        rice_len = 5'(zeros) + 5'd4;
        rice_cw  = {12'd0, 1'b1, u_val[2:0]};
      end
      default: begin
        in_range = 1'b0;
        zeros    = '0;
        rice_len = '0;
        rice_cw  = '0;
      end
    endcase
  end

  always_comb begin
    app_len   = (req_i.req_type == rbp_pkg::REQ_RICE) ? rice_len : fix_len;
    app_code  = (req_i.req_type == rbp_pkg::REQ_RICE) ? rice_cw : fix_code;
    app_acc   = ({16'd0, pend_bits_q} << app_len) | {16'd0, app_code};
    app_total = {1'b0, pend_cnt_q} + app_len;
    app_rest  = app_total[rbp_pkg::CntW-1:0];
    app_word  = app_acc >> app_rest;
    rest_mask = (32'd1 << app_rest) - 32'd1;
    flush_sh  = 5'd16 - {1'b0, pend_cnt_q};
  end

  always_comb begin
    pend_bits_d        = pend_bits_q;
    pend_cnt_d         = pend_cnt_q;
    words_done_d       = words_done_q;
    res_d.word_valid   = 1'b0;
    res_d.packed_word  = '0;
    res_d.status       = rbp_pkg::ST_OK;
    res_d.block_done   = req_i.block_last;
    case (rbp_pkg::req_type_e'(req_i.req_type))
      rbp_pkg::REQ_FIXED, rbp_pkg::REQ_RICE: begin
        if (req_i.req_type == rbp_pkg::REQ_RICE && !in_range) begin
          res_d.status = rbp_pkg::ST_RANGE;
        end else if (app_total[4]) begin
          if (full) begin
            res_d.status = rbp_pkg::ST_FULL;
          end else begin
            res_d.word_valid  = 1'b1;
            res_d.packed_word = app_word[rbp_pkg::WordW-1:0];
            words_done_d      = words_done_q + 17'd1;
            pend_bits_d       = app_acc[rbp_pkg::WordW-1:0] & rest_mask[rbp_pkg::WordW-1:0];
            pend_cnt_d        = app_rest;
          end
        end else begin
          pend_bits_d = app_acc[rbp_pkg::WordW-1:0];
          pend_cnt_d  = app_rest;
        end
        res_d.words_total = words_done_d;
      end
      rbp_pkg::REQ_FLUSH: begin
        res_d.words_total = words_done_q;
        if (pend_cnt_q != '0) begin
          if (full) begin
            res_d.status = rbp_pkg::ST_FULL;
          end else begin
            res_d.word_valid  = 1'b1;
            res_d.packed_word = pend_bits_q << flush_sh;
            res_d.words_total = words_done_q + 17'd1;
          end
        end
      end
      default: begin
        res_d.words_total = words_done_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_words_q <= rbp_pkg::BUFFER_WORDS_RST;
      pend_bits_q    <= '0;
      pend_cnt_q     <= '0;
      words_done_q   <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        buffer_words_q <= cfg_wdata_i;
      end
      if (acc) begin
        pend_bits_q  <= pend_bits_d;
        pend_cnt_q   <= pend_cnt_d;
        words_done_q <= words_done_d;
        res_valid_q  <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.word_valid  = res_q.word_valid;
  assign res_o.packed_word = res_q.packed_word;
  assign res_o.words_total = res_q.words_total;
  assign res_o.status      = res_q.status;
  assign res_o.block_done  = res_q.block_done;

`ifndef SYNTH
  a_drop_holds_state: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    acc && (res_d.status != rbp_pkg::ST_OK) |=>
      $stable(pend_cnt_q) && $stable(pend_bits_q) && $stable(words_done_q)
  ) else $error("rejected request changed packing state");

  a_count_needs_word: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (words_done_q != $past(words_done_q)) |->
      res_valid_q && res_q.word_valid && (res_q.words_total == words_done_q)
  ) else $error("word count moved without an emitted word");

  a_idle_word_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.word_valid |-> (res_q.packed_word == '0)
  ) else $error("packed word not zero without a word");
`endif

endmodule

/* bench/rbp_checker.sv */
// Scoreboard for the rice bit packer: predicts each result and compares it.
module rbp_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbp_pkg::WordW-1:0]  cfg_wdata_i,
  rbp_req_if                         req,
  rbp_res_if                         res,
  output int unsigned                mismatches,
  output int unsigned                results_owed,
  output logic [rbp_pkg::TotalW-1:0] words_packed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NoneLo  = -6;
  localparam int NoneHi  = 7;
  localparam int OneLo   = -11;
  localparam int OneHi   = 10;
  localparam int ThreeLo = -28;
  localparam int ThreeHi = 27;

  logic [rbp_pkg::WordW-1:0]  capacity;
  logic [rbp_pkg::WordW-1:0]  pend_bits;
  logic [rbp_pkg::CntW-1:0]   pend_cnt;
  logic [rbp_pkg::TotalW-1:0] words_done;
  rbp_pkg::res_t              predicted_words[$];
  rbp_pkg::res_t              exp_res;
  rbp_pkg::res_t              got_res;

  function automatic rbp_pkg::res_t pack_request(input logic [rbp_pkg::ReqW-1:0] kind,
                                                 input logic [rbp_pkg::WordW-1:0] smp,
                                                 input logic [rbp_pkg::FieldW-1:0] nbits,
                                                 input logic [rbp_pkg::CodeW-1:0] code,
                                                 input logic last);
    rbp_pkg::res_t r;
    int unsigned   len;
    int unsigned   sfx;
    int unsigned   u;
    int unsigned   fill;
    int unsigned   rest;
    int            v;
    int            lo;
    int            hi;
    logic [31:0]   cw;
    logic [31:0]   acc;
    logic [31:0]   shifted;
    logic [31:0]   kept;
    bit            append;
    r = '0;
    r.block_done = last;
    r.status = rbp_pkg::ST_OK;
    append = 1'b0;
    len = 0;
    cw = '0;
    case (kind)
      rbp_pkg::REQ_FIXED: begin
        len = (nbits > rbp_pkg::WordW) ? rbp_pkg::WordW : nbits;
        cw = {16'h0, smp} & ((32'd1 << len) - 32'd1);
        append = 1'b1;
      end
      rbp_pkg::REQ_RICE: begin
        v = $signed(smp);
        sfx = 0;
        lo = 1;
        hi = 0;
        case (code)
          rbp_pkg::RICE_NONE: begin
            sfx = 0; lo = NoneLo; hi = NoneHi;
          end
          rbp_pkg::RICE_ONE: begin
            sfx = 1; lo = OneLo; hi = OneHi;
          end
          rbp_pkg::RICE_THREE: begin
            sfx = 3; lo = ThreeLo; hi = ThreeHi;
          end
          default: begin
          end
        endcase
        if (v < lo || v > hi) begin
          r.status = rbp_pkg::ST_RANGE;
        end else begin
          u = (v >= 0) ? 2 * v : -2 * v - 1;
          len = (u >> sfx) + 1 + sfx;
          cw = (32'd1 << sfx) | (u & ((32'd1 << sfx) - 32'd1));
          append = 1'b1;
        end
      end
      rbp_pkg::REQ_FLUSH: begin
        r.words_total = words_done;
        if (pend_cnt != 0) begin
          if (words_done >= capacity) begin
            r.status = rbp_pkg::ST_FULL;
          end else begin
            r.word_valid = 1'b1;
            r.packed_word = pend_bits << (rbp_pkg::WordW - pend_cnt);
            r.words_total = words_done + 17'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (append) begin
      acc = ({16'h0, pend_bits} << len) | cw;
      fill = pend_cnt + len;
      if (fill >= rbp_pkg::WordW) begin
        rest = fill - rbp_pkg::WordW;
        if (words_done >= capacity) begin
          r.status = rbp_pkg::ST_FULL;
        end else begin
          shifted = acc >> rest;
          kept = acc & ((32'd1 << rest) - 32'd1);
          r.word_valid = 1'b1;
          r.packed_word = shifted[15:0];
          words_done = words_done + 17'd1;
          pend_bits = kept[15:0];
          pend_cnt = 4'(rest);
        end
      end else begin
        pend_bits = acc[15:0];
        pend_cnt = 4'(fill);
      end
    end
    if (kind != rbp_pkg::REQ_FLUSH) r.words_total = words_done;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = rbp_pkg::BUFFER_WORDS_RST;
      pend_bits = '0;
      pend_cnt = '0;
      words_done = '0;
      mismatches = 0;
      predicted_words.delete();
    end else begin
      if (res.valid && res.ready) begin
        got_res = {res.word_valid, res.packed_word, res.words_total, res.status,
                   res.block_done};
        if (predicted_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result valid=%0b word=%h total=%0d status=%0d done=%0b",
                   $time, got_res.word_valid, got_res.packed_word, got_res.words_total,
                   got_res.status, got_res.block_done);
        end else begin
          exp_res = predicted_words.pop_front();
          if (got_res !== exp_res) begin
            mismatches++;
            $display("%0t: mismatch expected valid=%0b word=%h total=%0d status=%0d done=%0b",
                     $time, exp_res.word_valid, exp_res.packed_word, exp_res.words_total,
                     exp_res.status, exp_res.block_done);
            $display("%0t:          actual   valid=%0b word=%h total=%0d status=%0d done=%0b",
                     $time, got_res.word_valid, got_res.packed_word, got_res.words_total,
                     got_res.status, got_res.block_done);
          end
        end
      end
      if (req.valid && req.ready) begin
        predicted_words.push_back(pack_request(req.req_type, req.sample, req.field_bits,
                                               req.rice_code, req.block_last));
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
    end
    results_owed = predicted_words.size();
    words_packed = words_done;
  end

endmodule

/* bench/testbench.sv */
// Top of the rice bit packer bench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rbp_pkg::ReqW-1:0]  REQ_NOP  = 2'd3;
  localparam logic [rbp_pkg::CodeW-1:0] RICE_BAD = 2'd3;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [rbp_pkg::WordW-1:0]  cfg_wdata_i;
  int unsigned                mismatches;
  int unsigned                results_owed;
  logic [rbp_pkg::TotalW-1:0] words_packed;
  bit                         steady;

  rbp_req_if req_ch ();
  rbp_res_if res_ch ();

  rice_bit_packer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  rbp_checker packer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_ch),
    .res          (res_ch),
    .mismatches   (mismatches),
    .results_owed (results_owed),
    .words_packed (words_packed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic [rbp_pkg::ReqW-1:0] kind, input int value,
                      input logic [rbp_pkg::FieldW-1:0] nbits,
                      input logic [rbp_pkg::CodeW-1:0] code,
                      input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.sample     <= value[15:0];
    req_ch.field_bits <= nbits;
    req_ch.rice_code  <= code;
    req_ch.block_last <= last;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [rbp_pkg::WordW-1:0] words);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= words;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned                 pick;
    int                          lo;
    int                          hi;
    int                          value;
    logic [rbp_pkg::ReqW-1:0]    kind;
    logic [rbp_pkg::FieldW-1:0]  nbits;
    logic [rbp_pkg::CodeW-1:0]   code;
    repeat (count) begin
      pick  = $urandom_range(0, 99);
      nbits = 5'($urandom_range(1, 16));
      code  = 2'($urandom_range(0, 2));
      value = $urandom();
      if (pick < 40) kind = rbp_pkg::REQ_FIXED;
      else if (pick < 88) kind = rbp_pkg::REQ_RICE;
      else if (pick < 96) kind = rbp_pkg::REQ_FLUSH;
      else kind = REQ_NOP;
      if ($urandom_range(0, 9) == 0) nbits = 5'($urandom());
      if ($urandom_range(0, 19) == 0) code = 2'($urandom());
      if (kind == rbp_pkg::REQ_RICE && $urandom_range(0, 4) != 0) begin
        case (code)
          rbp_pkg::RICE_ONE:   begin lo = -11; hi = 10; end
          rbp_pkg::RICE_THREE: begin lo = -28; hi = 27; end
          default:             begin lo = -6;  hi = 7;  end
        endcase
        value = int'($urandom_range(0, hi - lo + 2)) + lo - 1;
      end
      send(kind, value, nbits, code, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    forever begin
      res_ch.ready <= (rst_ni === 1'b1);
      @(posedge clk_i);
      if (rst_ni === 1'b1) begin
        repeat ($urandom_range(0, 20)) @(posedge clk_i);
        if (pick_gap() > 0) begin
          res_ch.ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = rbp_pkg::REQ_FIXED;
    req_ch.sample     = '0;
    req_ch.field_bits = '0;
    req_ch.rice_code  = rbp_pkg::RICE_NONE;
    req_ch.block_last = 1'b0;
    steady            = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(rbp_pkg::REQ_FLUSH, 0, 5'd0, rbp_pkg::RICE_NONE, 1'b1);
    send(rbp_pkg::REQ_FIXED, 'hffff, 5'd16, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_FIXED, 'h8000, 5'd16, rbp_pkg::RICE_ONE, 1'b1);
    send(rbp_pkg::REQ_FIXED, 1, 5'd1, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_FLUSH, 0, 5'd0, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_FLUSH, 0, 5'd0, rbp_pkg::RICE_NONE, 1'b1);
    send(rbp_pkg::REQ_FIXED, 'h7fff, 5'd15, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_FIXED, 'hffff, 5'd0, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_FIXED, 'h1234, 5'd31, rbp_pkg::RICE_NONE, 1'b1);
    send(rbp_pkg::REQ_RICE, -6, 5'd0, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_RICE, 7, 5'd0, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_RICE, 8, 5'd0, rbp_pkg::RICE_NONE, 1'b1);
    send(rbp_pkg::REQ_RICE, -7, 5'd0, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_RICE, -11, 5'd0, rbp_pkg::RICE_ONE, 1'b0);
    send(rbp_pkg::REQ_RICE, 10, 5'd0, rbp_pkg::RICE_ONE, 1'b1);
    send(rbp_pkg::REQ_RICE, 11, 5'd0, rbp_pkg::RICE_ONE, 1'b0);
    send(rbp_pkg::REQ_RICE, -28, 5'd0, rbp_pkg::RICE_THREE, 1'b0);
    send(rbp_pkg::REQ_RICE, 27, 5'd0, rbp_pkg::RICE_THREE, 1'b1);
    send(rbp_pkg::REQ_RICE, -29, 5'd0, rbp_pkg::RICE_THREE, 1'b0);
    send(rbp_pkg::REQ_RICE, 0, 5'd0, RICE_BAD, 1'b0);
    send(rbp_pkg::REQ_RICE, 0, 5'd0, rbp_pkg::RICE_NONE, 1'b1);
    send(rbp_pkg::REQ_RICE, -32768, 5'd0, rbp_pkg::RICE_NONE, 1'b0);
    send(rbp_pkg::REQ_FIXED, 'h7fff, 5'd5, rbp_pkg::RICE_NONE, 1'b0);
    send(REQ_NOP, 'h5a5a, 5'd7, rbp_pkg::RICE_ONE, 1'b1);
    send(rbp_pkg::REQ_FLUSH, 0, 5'd0, rbp_pkg::RICE_NONE, 1'b0);

    set_capacity(16'hffff);
    send_random(350);
    set_capacity(words_packed[rbp_pkg::WordW-1:0] + 16'd4);
    send_random(150);
    set_capacity(16'd1);
    send_random(60);
    set_capacity(16'd0);
    send_random(40);
    set_capacity(16'hffff);
    steady = 1'b1;
    send_random(200);
    steady = 1'b0;
    drain();
    send_random(400);
    drain();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && results_owed == 0) begin
      $display("rice_bit_packer regression: pass");
    end else begin
      $display("rice_bit_packer regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rice_bit_packer regression: fail");
    $finish;
  end

endmodule

/* rice_bit_packer.f */
rtl/rbp_pkg.sv
rtl/rbp_req_if.sv
rtl/rbp_res_if.sv
rtl/rice_bit_packer.sv
bench/rbp_checker.sv
bench/testbench.sv
